@@ rtl/core/rdws_pkg.sv @@
// Shared constants for the ring deque with search: field widths,
// operation codes and status codes. No dependencies.
package rdws_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int POSITION_W  = 4;
  localparam int OCCUPANCY_W = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_APPEND = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_REMOVE = 3'd2;
  localparam op_t OP_CLEAR  = 3'd3;
  localparam op_t OP_SEARCH = 3'd4;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FIRST = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;
  localparam status_t STATUS_EMPTY = 2'd3;

endpackage

@@ rtl/core/ring_deque_with_search.sv @@
// Ring deque with search: top level, ring memory and sequencer; uses rdws_pkg.
// Every op passes through the states EXEC and RESULT before out_valid; a search
// also walks SRCH, reading entries from the head until a hit or the occupancy.
// A new item is taken only when the sequencer is idle, so one op runs at a time
// with one memory read port and one comparator; a full output register stalls it.
// Reset: synchronous active-low; head and count go to zero, memory is left.
module ring_deque_with_search
  import rdws_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           in_op,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_found,
  output logic [POSITION_W-1:0]     out_position,
  output logic [OCCUPANCY_W-1:0]    out_occupancy
);

  // Index into the ring, count of held values (0..DEPTH), and a sum of two.
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = CW + 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SRCH   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  // Ring memory: written at one address, read at one, read data registered.
  logic signed [VALUE_W-1:0] ring_mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [AW-1:0]             rd_addr;

  logic [1:0]                state_r, state_nxt;
  op_t                       op_r, op_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;       // next entry to read
  logic                      cmp_vld_r, cmp_vld_nxt; // rd_data_r holds a live entry
  logic [CW-1:0]             cmp_pos_r, cmp_pos_nxt; // its position from head
  status_t                   status_r, status_nxt;
  logic                      found_r, found_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]           out_status_r, out_status_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [POSITION_W-1:0]         out_position_r, out_position_nxt;
  logic [OCCUPANCY_W-1:0]        out_occupancy_r, out_occupancy_nxt;

  // Ring address arithmetic: wrap a sum below 2*DEPTH with one compare.
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] srch_sum;
  logic [AW-1:0]    tail_idx;
  logic [AW-1:0]    srch_idx;
  logic [AW-1:0]    head_inc;
  logic [AW-1:0]    head_dec;

  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign srch_sum = SUM_W'(head_r) + SUM_W'(idx_r);
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? AW'(tail_sum - SUM_W'(DEPTH))
                                                : AW'(tail_sum);
  assign srch_idx = (srch_sum >= SUM_W'(DEPTH)) ? AW'(srch_sum - SUM_W'(DEPTH))
                                                : AW'(srch_sum);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  assign rd_addr = srch_idx;

  // Take a new item whenever the sequencer is idle; a finished result
  // waits in the output register meanwhile.
  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_position  = out_position_r;
  assign out_occupancy = out_occupancy_r;

  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    value_nxt         = value_r;
    head_nxt          = head_r;
    count_nxt         = count_r;
    idx_nxt           = idx_r;
    cmp_vld_nxt       = 1'b0;
    cmp_pos_nxt       = cmp_pos_r;
    status_nxt        = status_r;
    found_nxt         = found_r;
    pos_nxt           = pos_r;
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_found_nxt     = out_found_r;
    out_position_nxt  = out_position_r;
    out_occupancy_nxt = out_occupancy_r;
    mem_we            = 1'b0;
    mem_waddr         = head_r;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          value_nxt = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = STATUS_OK;
        found_nxt  = 1'b0;
        pos_nxt    = '0;
        state_nxt  = S_RESULT;
        case (op_r)
          OP_APPEND, OP_INSERT: begin
            if (count_r == '0) begin
              // First value lands in the head slot for either end.
              mem_we     = 1'b1;
              mem_waddr  = head_r;
              count_nxt  = CW'(1);
              status_nxt = STATUS_FIRST;
            end else if (count_r == CW'(DEPTH)) begin
              status_nxt = STATUS_FULL;
            end else if (op_r == OP_APPEND) begin
              mem_we    = 1'b1;
              mem_waddr = tail_idx;
              count_nxt = count_r + CW'(1);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
            end else begin
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
            end
          end
          OP_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          OP_SEARCH: begin
            idx_nxt   = '0;
            state_nxt = S_SRCH;
          end
          default: begin
            // Unknown op: leave head, count and memory as they are; report the unchanged count.
          end
        endcase
      end

      S_SRCH: begin
        // Compare the entry read last cycle while reading the next one.
        if (cmp_vld_r && (rd_data_r == value_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = cmp_pos_r;
          state_nxt = S_RESULT;
        end else if (idx_r == count_r) begin
          state_nxt = S_RESULT;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_pos_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end
      end

      S_RESULT: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = status_r;
          out_found_nxt     = found_r;
          out_position_nxt  = POSITION_W'(pos_r);
          out_occupancy_nxt = OCCUPANCY_W'(count_r);
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= value_r;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    value_r         <= value_nxt;
    idx_r           <= idx_nxt;
    cmp_pos_r       <= cmp_pos_nxt;
    status_r        <= status_nxt;
    found_r         <= found_nxt;
    pos_r           <= pos_nxt;
    out_status_r    <= out_status_nxt;
    out_found_r     <= out_found_nxt;
    out_position_r  <= out_position_nxt;
    out_occupancy_r <= out_occupancy_nxt;
  end

endmodule
